@@ rtl/core/decimal_bigint_add_multiply_top_macros.svh @@
// Assertion macros shared by the decimal add and multiply block.
`ifndef DECIMAL_BIGINT_ADD_MULTIPLY_TOP_MACROS_SVH
`define DECIMAL_BIGINT_ADD_MULTIPLY_TOP_MACROS_SVH
`ifndef SYNTH
`define DBAM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define DBAM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DBAM_ASSERT_ALWAYS(lbl, expr, msg)
`define DBAM_ASSERT_SAME(lbl, ante, cons, msg)
`define DBAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/dbam_pkg.sv @@
// Package with the constants, types and digit helpers of the decimal add and multiply block.
package dbam_pkg;

  localparam int DIGITS = 32;
  localparam int IDX_W  = $clog2(DIGITS);
  localparam int POS_W  = $clog2(DIGITS + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;

  typedef logic [3:0]       digit_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic load;
    logic start;
    logic add_step;
    logic mul_step;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
    logic out_free;
  } sts_t;

  // Quotient by ten of an 8-bit value, taken as the product with 205 shifted right by 11.
  function automatic logic [4:0] div10_q(input logic [7:0] p);
    logic [15:0] m;
    m = {8'd0, p} * 16'd205;
    return m[15:11];
  endfunction

  function automatic digit_t mod10(input logic [7:0] p, input logic [4:0] q);
    logic [7:0] t;
    t = p - ({3'b000, q} << 3) - ({3'b000, q} << 1);
    return t[3:0];
  endfunction

endpackage

@@ rtl/core/dbam_in_if.sv @@
// Input channel carrying one digit pair and its operation code per transaction.
interface dbam_in_if import dbam_pkg::*; ();
  logic       valid;
  logic       ready;
  digit_t     digit_a;
  digit_t     digit_b;
  logic [1:0] operation;
  logic       last_digit;

  modport source (output valid, output digit_a, output digit_b, output operation,
                  output last_digit, input ready);
  modport sink (input valid, input digit_a, input digit_b, input operation,
                input last_digit, output ready);
endinterface

@@ rtl/core/dbam_out_if.sv @@
// Output channel carrying one result digit per transaction.
interface dbam_out_if import dbam_pkg::*; ();
  logic   valid;
  logic   ready;
  digit_t result_digit;
  logic   equal_flag;
  logic   last_result;

  modport source (output valid, output result_digit, output equal_flag,
                  output last_result, input ready);
  modport sink (input valid, input result_digit, input equal_flag,
                input last_result, output ready);
endinterface

@@ rtl/core/dbam_ctrl.sv @@
// Controller state machine that sequences loading, the column steps and the result output.
module dbam_ctrl import dbam_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_ADD  = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start = 1'b1;
            if (in_op == OP_ADD) begin
              state_next = S_ADD;
            end else if (in_op == OP_MUL) begin
              state_next = S_MUL;
            end else begin
              state_next = S_FIN;
            end
          end
        end
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        if (sts.col_last) begin
          state_next = S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.col_last && sts.row_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.col_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/core/dbam_dp.sv @@
// Datapath with the operand and accumulator digit stores, the column step unit and output register.
`include "decimal_bigint_add_multiply_top_macros.svh"
module dbam_dp import dbam_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  digit_t     digit_a,
  input  digit_t     digit_b,
  input  logic [1:0] operation,
  input  logic       out_ready,
  output logic       out_valid,
  output digit_t     result_digit,
  output logic       equal_flag,
  output logic       last_result
);

  digit_t     a_mem [DIGITS];
  digit_t     b_mem [DIGITS];
  digit_t     acc_mem [DIGITS];
  pos_t       load_pos;
  logic       eq_run;
  logic       eq_hold;
  logic       is_cmp;
  idx_t       row;
  idx_t       col;
  logic [4:0] rem;
  logic       carry;
  logic       out_last;

  idx_t       a_idx;
  idx_t       b_idx;
  digit_t     a_rd;
  digit_t     b_rd;
  digit_t     acc_eff;
  logic [7:0] prod;
  logic [7:0] p_sel;
  logic [4:0] q;
  digit_t     r;
  logic [4:0] s_mul;
  logic       s_carry;
  digit_t     wr_digit;
  logic       can_store;

  assign sts.col_last = (col == idx_t'(DIGITS - 1));
  assign sts.row_last = (row == idx_t'(DIGITS - 1));
  assign sts.out_free = !out_valid || out_ready;

  assign can_store = (load_pos < pos_t'(DIGITS));

  assign a_idx   = col - row;
  assign b_idx   = cmd.mul_step ? row : col;
  assign a_rd    = (pos_t'(a_idx) < load_pos) ? a_mem[a_idx] : 4'd0;
  assign b_rd    = (pos_t'(b_idx) < load_pos) ? b_mem[b_idx] : 4'd0;
  assign acc_eff = (row == '0) ? 4'd0 : acc_mem[col];

  assign prod  = {4'b0000, a_rd} * {4'b0000, b_rd};
  assign p_sel = cmd.mul_step ? (prod + {3'b000, rem})
                              : ({4'b0000, a_rd} + {4'b0000, b_rd} + {3'b000, rem});
  assign q     = div10_q(p_sel);
  assign r     = mod10(p_sel, q);

  assign s_mul    = {1'b0, acc_eff} + {1'b0, r} + {4'b0000, carry};
  assign s_carry  = (s_mul >= 5'd10);
  assign wr_digit = cmd.mul_step ? (s_carry ? 4'(s_mul - 5'd10) : s_mul[3:0]) : r;

  always_ff @(posedge clk) begin
    if (cmd.load && can_store) begin
      a_mem[load_pos[IDX_W-1:0]] <= digit_a;
      b_mem[load_pos[IDX_W-1:0]] <= digit_b;
    end
    if (cmd.add_step || cmd.mul_step) begin
      acc_mem[col] <= wr_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos  <= '0;
      eq_run    <= 1'b1;
      eq_hold   <= 1'b1;
      is_cmp    <= 1'b0;
      row       <= '0;
      col       <= '0;
      rem       <= '0;
      carry     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && can_store) begin
        load_pos <= load_pos + pos_t'(1);
        eq_run   <= eq_run && (digit_a == digit_b);
      end
      if (cmd.start) begin
        row    <= '0;
        col    <= '0;
        rem    <= '0;
        carry  <= 1'b0;
        is_cmp <= !((operation == OP_ADD) || (operation == OP_MUL));
      end
      if (cmd.add_step) begin
        rem <= q;
        col <= col + idx_t'(1);
      end
      if (cmd.mul_step) begin
        if (sts.col_last) begin
          row   <= row + idx_t'(1);
          col   <= row + idx_t'(1);
          rem   <= '0;
          carry <= 1'b0;
        end else begin
          col   <= col + idx_t'(1);
          rem   <= q;
          carry <= s_carry;
        end
      end
      if (cmd.finish) begin
        eq_hold  <= eq_run;
        eq_run   <= 1'b1;
        load_pos <= '0;
        col      <= '0;
      end
      if (cmd.emit) begin
        col       <= col + idx_t'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_digit <= is_cmp ? 4'd0 : acc_mem[col];
      equal_flag   <= eq_hold;
      out_last     <= sts.col_last;
    end
  end

  assign last_result = out_last;

  `DBAM_ASSERT_ALWAYS(a_rem_bound, rem <= 5'd24, "Product carry out of range.")
  `DBAM_ASSERT_ALWAYS(a_fill_bound, load_pos <= pos_t'(DIGITS),
                      "Fill count past the store depth.")
  `DBAM_ASSERT_SAME(a_digit_decimal, cmd.add_step || cmd.mul_step, wr_digit <= 4'd9,
                    "Written digit is not decimal.")
  `DBAM_ASSERT_NEXT(a_last_closes, cmd.emit && sts.col_last, out_valid && out_last,
                    "Top digit not marked last.")

endmodule

@@ rtl/core/decimal_bigint_add_multiply_top.sv @@
// Top level of the fixed-width decimal adder, multiplier and equality tester.
//
// The operands channel takes one digit pair per transaction, least significant first, at
// one transaction per cycle while loading. Positions never loaded count as zero and pairs
// past DIGITS are dropped. The transaction marked last_digit selects the operation: add,
// multiply, or an equality test (codes two and three).
// After that transaction the block computes with one column step unit, one digit per cycle:
// add steps through every column, multiply from each row's column up, one row of the second
// operand after the other, compare none; a finish state then latches the equality flag.
// The results channel then gives DIGITS transactions, least significant digit first, the top
// one marked last_result, one per cycle while the receiver takes them.
// A stall holds the output register and the digit walk; the next operand load is accepted
// as soon as the top digit sits in the output register.
// Reset is synchronous and leaves the block empty and ready for a first operand pair.
module decimal_bigint_add_multiply_top import dbam_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dbam_in_if.sink           operands,
  dbam_out_if.source        results
);

  cmd_t cmd;
  sts_t sts;

  dbam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_last  (operands.last_digit),
    .in_op    (operands.operation),
    .in_ready (operands.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dbam_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .digit_a      (operands.digit_a),
    .digit_b      (operands.digit_b),
    .operation    (operands.operation),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .result_digit (results.result_digit),
    .equal_flag   (results.equal_flag),
    .last_result  (results.last_result)
  );

endmodule

@@ test/decimal_bigint_add_multiply_checker.sv @@
// Checker that predicts and compares the result digits of the decimal add and multiply block.
module decimal_bigint_add_multiply_checker import dbam_pkg::*; (
  input  logic clk,
  input  logic rst,
  dbam_in_if   operands,
  dbam_out_if  results,
  output int   errors,
  output int   pending
);

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    digit_t digit;
    logic   equal;
    logic   top;
  } digit_result_t;

  digit_t        first_digits[DIGITS];
  digit_t        second_digits[DIGITS];
  int unsigned   load_count;
  int            mismatches;
  digit_result_t oldest;
  digit_result_t expected_digits[$];

  task automatic clear_operands();
    for (int i = 0; i < DIGITS; i++) begin
      first_digits[i] = '0;
      second_digits[i] = '0;
    end
    load_count = 0;
  endtask

  task automatic load_pair(input digit_t a, input digit_t b, input logic [1:0] op,
                           input logic last);
    int unsigned sum_digits[DIGITS];
    int unsigned carry;
    int unsigned spill;
    int unsigned mult;
    int unsigned prod;
    int unsigned s;
    logic        same;
    if (load_count < DIGITS) begin
      first_digits[load_count] = a;
      second_digits[load_count] = b;
      load_count++;
    end
    if (last) begin
      same = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        if (first_digits[i] != second_digits[i]) begin
          same = 1'b0;
        end
        sum_digits[i] = 0;
      end
      if (op == OP_ADD) begin
        carry = 0;
        for (int i = 0; i < DIGITS; i++) begin
          s = first_digits[i] + second_digits[i] + carry;
          sum_digits[i] = s % RADIX;
          carry = s / RADIX;
        end
      end else if (op == OP_MUL) begin
        for (int row = 0; row < DIGITS; row++) begin
          mult = second_digits[row];
          spill = 0;
          carry = 0;
          for (int col = row; col < DIGITS; col++) begin
            prod = first_digits[col - row] * mult + spill;
            spill = prod / RADIX;
            s = sum_digits[col] + prod % RADIX + carry;
            sum_digits[col] = s % RADIX;
            carry = s / RADIX;
          end
        end
      end
      for (int k = 0; k < DIGITS; k++) begin
        expected_digits.push_back('{digit_t'(sum_digits[k]), same, k == DIGITS - 1});
      end
      clear_operands();
    end
  endtask

  // A result transaction is compared before the operand transaction of the same edge is
  // predicted, since a new operation cannot produce results in the cycle it starts.
  always @(posedge clk) begin
    if (rst) begin
      clear_operands();
      expected_digits.delete();
      mismatches = 0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected result transaction: result_digit %0d equal_flag %0d",
                 results.result_digit, results.equal_flag);
          mismatches++;
        end else begin
          oldest = expected_digits.pop_front();
          if (results.result_digit !== oldest.digit) begin
            $error("result_digit: expected %0d, actual %0d", oldest.digit,
                   results.result_digit);
            mismatches++;
          end
          if (results.equal_flag !== oldest.equal) begin
            $error("equal_flag: expected %0d, actual %0d", oldest.equal,
                   results.equal_flag);
            mismatches++;
          end
          if (results.last_result !== oldest.top) begin
            $error("last_result: expected %0d, actual %0d", oldest.top,
                   results.last_result);
            mismatches++;
          end
        end
      end
      if (operands.valid && operands.ready) begin
        load_pair(operands.digit_a, operands.digit_b, operands.operation,
                  operands.last_digit);
      end
      pending <= expected_digits.size();
      errors <= mismatches;
    end
  end

endmodule

@@ test/decimal_bigint_add_multiply_top_tb.sv @@
// Testbench top that drives operand digits and result stalls and reports the verdict.
module decimal_bigint_add_multiply_top_tb import dbam_pkg::*; ();

  localparam logic [1:0] OP_CMP   = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int ITEM_TARGET  = 350;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 64;

  logic        clk;
  logic        rst;
  logic        calm;
  int          errors;
  int          pending;
  int          items_sent;
  int unsigned cycle_count;

  dbam_in_if  operands_ch ();
  dbam_out_if results_ch ();

  decimal_bigint_add_multiply_top dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .results  (results_ch)
  );

  decimal_bigint_add_multiply_checker digit_check (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .results  (results_ch),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results_ch.ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic digit_t any_digit();
    if ($urandom_range(11) == 0) begin
      return digit_t'($urandom_range(15, 10));
    end
    return digit_t'($urandom_range(9));
  endfunction

  task automatic send_pair(input digit_t a, input digit_t b, input logic [1:0] op,
                           input logic last);
    while (!calm && $urandom_range(99) < 35) begin
      operands_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operands_ch.valid      <= 1'b1;
    operands_ch.digit_a    <= a;
    operands_ch.digit_b    <= b;
    operands_ch.operation  <= op;
    operands_ch.last_digit <= last;
    @(posedge clk);
    while (!operands_ch.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    operands_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int         len;
    int         style;
    int         pick;
    digit_t     a;
    digit_t     b;
    logic [1:0] op;
    rst                    <= 1'b1;
    calm                   <= 1'b0;
    operands_ch.valid      <= 1'b0;
    operands_ch.digit_a    <= '0;
    operands_ch.digit_b    <= '0;
    operands_ch.operation  <= OP_ADD;
    operands_ch.last_digit <= 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_pair(4'd9, 4'd9, OP_ADD, 1'b1);
    send_pair(4'd0, 4'd0, OP_ADD, 1'b1);
    send_pair(4'd15, 4'd15, OP_MUL, 1'b1);
    send_pair(4'd9, 4'd0, OP_SPARE, 1'b0);
    send_pair(4'd9, 4'd9, OP_MUL, 1'b1);
    send_pair(4'd12, 4'd12, OP_MUL, 1'b0);
    send_pair(4'd3, 4'd3, OP_CMP, 1'b1);
    send_pair(4'd4, 4'd5, OP_ADD, 1'b0);
    send_pair(4'd7, 4'd7, OP_SPARE, 1'b1);
    send_pair(4'd15, 4'd15, OP_ADD, 1'b0);
    send_pair(4'd9, 4'd9, OP_MUL, 1'b0);
    send_pair(4'd0, 4'd0, OP_ADD, 1'b1);
    send_pair(4'd9, 4'd9, OP_CMP, 1'b0);
    send_pair(4'd9, 4'd9, OP_ADD, 1'b0);
    send_pair(4'd9, 4'd9, OP_MUL, 1'b1);
    send_pair(4'd10, 4'd10, OP_ADD, 1'b0);
    send_pair(4'd15, 4'd15, OP_SPARE, 1'b1);
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      calm <= (items_sent >= 150) && (items_sent < 250);
      style = $urandom_range(99);
      len = ($urandom_range(4) == 0) ? DIGITS : $urandom_range(DIGITS, 1);
      if (style >= 88) begin
        len = $urandom_range(DIGITS + 3, 1);
      end
      pick = $urandom_range(99);
      op = (pick < 35) ? OP_ADD : (pick < 70) ? OP_MUL : (pick < 88) ? OP_CMP : OP_SPARE;
      for (int i = 0; i < len; i++) begin
        if (style < 60) begin
          a = any_digit();
          b = any_digit();
        end else if (style < 75) begin
          a = any_digit();
          b = a;
        end else if (style < 88) begin
          a = 4'd9;
          b = any_digit();
        end else begin
          a = digit_t'($urandom_range(15));
          b = digit_t'($urandom_range(15));
        end
        send_pair(a, b, (i == len - 1) ? op : 2'($urandom_range(3)), i == len - 1);
      end
    end
    calm <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
